// ===== rtl/core/s3rp_pkg.sv =====
`timescale 1ns / 1ps
// Package for the SHA-256 three-round precompute unit.
// Holds the working-variable type, round constants and the round functions.
// It depends on nothing else.
package s3rp_pkg;

	localparam int unsigned WordWidth = 32;

	typedef logic [WordWidth-1:0] word_t;

	typedef struct packed {
		word_t a;
		word_t b;
		word_t c;
		word_t d;
		word_t e;
		word_t f;
		word_t g;
		word_t h;
	} state_t;

	localparam word_t RoundK0 = 32'h428a2f98;
	localparam word_t RoundK1 = 32'h71374491;
	localparam word_t RoundK2 = 32'hb5c0fbcf;

	function automatic word_t big_sigma0(input word_t x);
		return {x[1:0], x[31:2]} ^ {x[12:0], x[31:13]} ^ {x[21:0], x[31:22]};
	endfunction

	function automatic word_t big_sigma1(input word_t x);
		return {x[5:0], x[31:6]} ^ {x[10:0], x[31:11]} ^ {x[24:0], x[31:25]};
	endfunction

	function automatic word_t choose(input word_t x, input word_t y, input word_t z);
		return (x & y) ^ (~x & z);
	endfunction

	function automatic word_t majority(input word_t x, input word_t y, input word_t z);
		return (x & y) ^ (x & z) ^ (y & z);
	endfunction

endpackage

// ===== rtl/core/sha256_three_round_precompute_unit.sv =====
`timescale 1ns / 1ps
// SHA-256 three-round precompute: a three-stage pipeline, one round per stage.
// An accepted request is registered in st_s1, st_s2 and st_s3 in turn before its result is on the output.
// Throughput is one request per cycle; a stalled output holds the pipeline in place.
// Reset clears the stage valid bits only; the payload registers are not reset.
// Depends on s3rp_pkg and s3rp_round.
module sha256_three_round_precompute_unit (
	input  logic         clk,
	input  logic         arst_n,
	input  logic         s_axis_tvalid,
	output logic         s_axis_tready,
	// mid_a, mid_b, mid_c, mid_d, mid_e, mid_f, mid_g, mid_h, msg_w0, msg_w1, msg_w2
	input  logic [351:0] s_axis_tdata,
	output logic         m_axis_tvalid,
	input  logic         m_axis_tready,
	// out_a, out_b, out_c, out_d, out_e, out_f, out_g, out_h
	output logic [255:0] m_axis_tdata
);

	s3rp_pkg::state_t in_state;
	s3rp_pkg::state_t rnd0_nxt;
	s3rp_pkg::state_t rnd1_nxt;
	s3rp_pkg::state_t rnd2_nxt;

	logic v_s1;
	logic v_s2;
	logic v_s3;
	s3rp_pkg::state_t st_s1;
	s3rp_pkg::state_t st_s2;
	s3rp_pkg::state_t st_s3;
	s3rp_pkg::word_t w1_s1;
	s3rp_pkg::word_t w2_s1;
	s3rp_pkg::word_t w2_s2;

	logic rdy1;
	logic rdy2;
	logic rdy3;

	always_comb begin
		in_state.a = s_axis_tdata[31:0];
		in_state.b = s_axis_tdata[63:32];
		in_state.c = s_axis_tdata[95:64];
		in_state.d = s_axis_tdata[127:96];
		in_state.e = s_axis_tdata[159:128];
		in_state.f = s_axis_tdata[191:160];
		in_state.g = s_axis_tdata[223:192];
		in_state.h = s_axis_tdata[255:224];
	end

	s3rp_round u_round0 (
		.cur(in_state),
		.w  (s_axis_tdata[287:256]),
		.k  (s3rp_pkg::RoundK0),
		.nxt(rnd0_nxt)
	);

	s3rp_round u_round1 (
		.cur(st_s1),
		.w  (w1_s1),
		.k  (s3rp_pkg::RoundK1),
		.nxt(rnd1_nxt)
	);

	s3rp_round u_round2 (
		.cur(st_s2),
		.w  (w2_s2),
		.k  (s3rp_pkg::RoundK2),
		.nxt(rnd2_nxt)
	);

	assign rdy3 = !v_s3 || m_axis_tready;
	assign rdy2 = !v_s2 || rdy3;
	assign rdy1 = !v_s1 || rdy2;
	assign s_axis_tready = rdy1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
		end else begin
			if (rdy1) begin
				v_s1 <= s_axis_tvalid;
			end
			if (rdy2) begin
				v_s2 <= v_s1;
			end
			if (rdy3) begin
				v_s3 <= v_s2;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (rdy1 && s_axis_tvalid) begin
			st_s1 <= rnd0_nxt;
			w1_s1 <= s_axis_tdata[319:288];
			w2_s1 <= s_axis_tdata[351:320];
		end
		if (rdy2 && v_s1) begin
			st_s2 <= rnd1_nxt;
			w2_s2 <= w2_s1;
		end
		if (rdy3 && v_s2) begin
			st_s3 <= rnd2_nxt;
		end
	end

	assign m_axis_tvalid = v_s3;
	assign m_axis_tdata = {st_s3.h, st_s3.g, st_s3.f, st_s3.e,
		st_s3.d, st_s3.c, st_s3.b, st_s3.a};

`ifndef NO_ASSERTIONS
	a_ready_when_drained: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tready |-> s_axis_tready)
		else $error("Input not ready although the output is being drained.");

	a_accept_fills_s1: assert property (@(posedge clk) disable iff (!arst_n)
		(s_axis_tvalid && s_axis_tready) |=> v_s1)
		else $error("Accepted request did not reach the first stage.");

	a_s1_held: assert property (@(posedge clk) disable iff (!arst_n)
		(v_s1 && !rdy2) |=> (v_s1 && $stable(st_s1)))
		else $error("First stage lost or changed a stalled request.");

	a_s2_advances: assert property (@(posedge clk) disable iff (!arst_n)
		(v_s2 && rdy3) |=> m_axis_tvalid)
		else $error("Second stage request did not reach the output.");
`endif

endmodule

// ===== rtl/core/s3rp_round.sv =====
`timescale 1ns / 1ps
// One SHA-256 compression round as combinational logic.
// Depends on s3rp_pkg for the state type and the round functions.
module s3rp_round (
	input  s3rp_pkg::state_t cur,
	input  s3rp_pkg::word_t  w,
	input  s3rp_pkg::word_t  k,
	output s3rp_pkg::state_t nxt
);

	s3rp_pkg::word_t t1;
	s3rp_pkg::word_t t2;

	assign t1 = cur.h + s3rp_pkg::big_sigma1(cur.e)
		+ s3rp_pkg::choose(cur.e, cur.f, cur.g) + k + w;
	assign t2 = s3rp_pkg::big_sigma0(cur.a) + s3rp_pkg::majority(cur.a, cur.b, cur.c);

	always_comb begin
		nxt.a = t1 + t2;
		nxt.b = cur.a;
		nxt.c = cur.b;
		nxt.d = cur.c;
		nxt.e = cur.d + t1;
		nxt.f = cur.e;
		nxt.g = cur.f;
		nxt.h = cur.g;
	end

endmodule
